// ===== design/ffbc_pkg.sv =====
// ----------------------------------------------------------------------------
// ffbc_pkg
// Shared constants and transaction types of the flat-field and background
// correction unit.
// ----------------------------------------------------------------------------
package ffbc_pkg;

  // Pixel bits that take part in the arithmetic (8 to 16).
  localparam int PIXEL_BITS     = 16;
  // Fraction bits of the flat-field mean (0 to MEAN_W - PIXEL_BITS, so 0 to 8 at 16-bit pixels).
  localparam int MEAN_FRAC_BITS = 8;

  // Fixed widths of the port fields.
  localparam int PORT_PIX_W = 16;
  localparam int MEAN_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int MODE_W     = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MEAN = CFG_IDX_W'(1);

  // Correction modes. The unused code behaves as background then flat field.
  localparam logic [MODE_W-1:0] MODE_BG_ONLY = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_FF_ONLY = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_BG_FF   = MODE_W'(2);

  localparam logic [MEAN_W-1:0] MEAN_RESET = MEAN_W'(1 << MEAN_FRAC_BITS);

  typedef struct packed {
    logic [PORT_PIX_W-1:0] raw_pixel;
    logic [PORT_PIX_W-1:0] offset_pixel;
    logic [PORT_PIX_W-1:0] gain_pixel;
    logic                  end_of_frame;
  } ffbc_in_t;

  typedef struct packed {
    logic [PORT_PIX_W-1:0] corrected_pixel;
    logic                  zero_gain;
    logic                  saturated;
    logic                  frame_end;
  } ffbc_out_t;

endpackage

// ===== design/flat_field_background_correction_unit.sv =====
// ----------------------------------------------------------------------------
// flat_field_background_correction_unit
// Per-pixel background subtraction and flat-field gain correction with a
// pipelined fixed-point divider.
// ----------------------------------------------------------------------------
//
// The unit takes one transaction per clock when not stalled: a raw pixel with
// its background and flat-field pixels, and returns one corrected pixel per
// transaction in the same order. Mode 0 gives max(0, raw - offset), mode 1
// gives floor(mean * raw / gain) and mode 2 (and the unused code 3) gives
// floor(mean * max(0, raw - offset) / gain), where mean is the unsigned
// fixed-point flat-field mean register. A zero gain pixel in a flat-field
// mode yields 0 with zero_gain set; a quotient above the pixel range is
// clamped to all ones with saturated set. The end-of-frame mark travels with
// its pixel. Throughput is one transaction per cycle while the output is not
// stalled. Data passes the subtraction, product and divider setup registers,
// then the restoring divider, which resolves two quotient bits in each of its
// pipeline stages, and then the output register. Each stage has its own valid
// bit and the ready chain lets bubbles collapse, so an output stall only
// holds the stages that actually carry data. Configuration registers are
// written through a plain write port and should only change while the unit
// is empty.
//
module flat_field_background_correction_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [ffbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ffbc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Pixel input channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ffbc_pkg::ffbc_in_t            in_data_i,
  // Corrected pixel output channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ffbc_pkg::ffbc_out_t           out_data_o
);
  import ffbc_pkg::*;

  localparam int PIX        = PIXEL_BITS;
  localparam int PROD_W     = MEAN_W + PIX;
  // The quotient is floor(P / (gain << FRAC)); bits of P above FRAC + PIX
  // form the initial partial remainder and decide saturation.
  localparam int TOP_W      = PROD_W - MEAN_FRAC_BITS - PIX;
  localparam int CMP_W      = (TOP_W > PIX) ? TOP_W : PIX;
  localparam int BITS_PER_STG = 2;
  localparam int DIV_STAGES = (PIX + BITS_PER_STG - 1) / BITS_PER_STG;

  typedef struct packed {
    logic [PIX-1:0] p;
    logic [PIX-1:0] gain;
    logic           use_ff;
    logic           eof;
  } pre_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [PIX-1:0]    p;
    logic [PIX-1:0]    gain;
    logic              use_ff;
    logic              eof;
  } mul_t;

  typedef struct packed {
    logic [PIX-1:0] rem;
    logic [PIX-1:0] dvd;
    logic [PIX-1:0] quot;
    logic [PIX-1:0] p;
    logic [PIX-1:0] gain;
    logic           use_ff;
    logic           zg;
    logic           ovf;
    logic           eof;
  } div_t;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [MODE_W-1:0] mode_q;
  logic [MEAN_W-1:0] mean_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BG_FF;
      mean_q <= MEAN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
        CFG_IDX_MEAN: mean_q <= cfg_data_i[MEAN_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits and the ready chain. A stage takes new data when it is empty
  // or when the stage after it takes its current contents.
  // --------------------------------------------------------------------------
  logic                pre_vld_q, mul_vld_q, out_vld_q;
  logic [DIV_STAGES:0] div_vld_q;
  logic                pre_rdy, mul_rdy, out_rdy;
  logic [DIV_STAGES:0] div_rdy;

  assign out_rdy = !out_vld_q || out_ready_i;
  assign div_rdy[DIV_STAGES] = !div_vld_q[DIV_STAGES] || out_rdy;
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_rdy
    assign div_rdy[k] = !div_vld_q[k] || div_rdy[k+1];
  end
  assign mul_rdy = !mul_vld_q || div_rdy[0];
  assign pre_rdy = !pre_vld_q || mul_rdy;

  assign in_ready_o  = pre_rdy;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
      mul_vld_q <= 1'b0;
      div_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (pre_rdy) pre_vld_q <= in_valid_i;
      if (mul_rdy) mul_vld_q <= pre_vld_q;
      if (div_rdy[0]) div_vld_q[0] <= mul_vld_q;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        if (div_rdy[k]) div_vld_q[k] <= div_vld_q[k-1];
      end
      if (out_rdy) out_vld_q <= div_vld_q[DIV_STAGES];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: background subtraction with clamp at zero, mode decode.
  // --------------------------------------------------------------------------
  pre_t           pre_d, pre_q;
  logic [PIX-1:0] raw_px, off_px;
  logic           use_bg;

  always_comb begin
    raw_px       = in_data_i.raw_pixel[PIX-1:0];
    off_px       = in_data_i.offset_pixel[PIX-1:0];
    use_bg       = (mode_q != MODE_FF_ONLY);
    pre_d.use_ff = (mode_q != MODE_BG_ONLY);
    pre_d.gain   = in_data_i.gain_pixel[PIX-1:0];
    pre_d.eof    = in_data_i.end_of_frame;
    if (use_bg) begin
      pre_d.p = (raw_px > off_px) ? (raw_px - off_px) : '0;
    end else begin
      pre_d.p = raw_px;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pre_rdy && in_valid_i) pre_q <= pre_d;
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale by the flat-field mean (exact product).
  // --------------------------------------------------------------------------
  mul_t mul_d, mul_q;

  always_comb begin
    mul_d.prod   = PROD_W'(mean_q) * PROD_W'(pre_q.p);
    mul_d.p      = pre_q.p;
    mul_d.gain   = pre_q.gain;
    mul_d.use_ff = pre_q.use_ff;
    mul_d.eof    = pre_q.eof;
  end

  always_ff @(posedge clk_i) begin
    if (mul_rdy && pre_vld_q) mul_q <= mul_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: saturation check and divider setup. When the upper product bits
  // are below the gain, the quotient fits the pixel range and those bits are
  // the first partial remainder.
  // --------------------------------------------------------------------------
  div_t             div_q [DIV_STAGES+1];
  div_t             init_d;
  logic [TOP_W-1:0] top_bits;

  always_comb begin
    top_bits      = mul_q.prod[PROD_W-1 -: TOP_W];
    init_d.ovf    = CMP_W'(top_bits) >= CMP_W'(mul_q.gain);
    init_d.zg     = (mul_q.gain == '0);
    init_d.rem    = top_bits[PIX-1:0];
    init_d.dvd    = mul_q.prod[MEAN_FRAC_BITS +: PIX];
    init_d.quot   = '0;
    init_d.p      = mul_q.p;
    init_d.gain   = mul_q.gain;
    init_d.use_ff = mul_q.use_ff;
    init_d.eof    = mul_q.eof;
  end

  always_ff @(posedge clk_i) begin
    if (div_rdy[0] && mul_vld_q) div_q[0] <= init_d;
  end

  // --------------------------------------------------------------------------
  // Divider stages: restoring division, two quotient bits per stage.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    div_t div_d;

    always_comb begin
      logic [PIX:0] part;
      logic         ge;
      div_d = div_q[k];
      for (int s = 0; s < BITS_PER_STG; s++) begin
        if (k * BITS_PER_STG + s < PIX) begin
          part       = {div_d.rem, div_d.dvd[PIX-1]};
          ge         = (part >= {1'b0, div_d.gain});
          div_d.rem  = ge ? PIX'(part - {1'b0, div_d.gain}) : part[PIX-1:0];
          div_d.dvd  = div_d.dvd << 1;
          div_d.quot = {div_d.quot[PIX-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (div_rdy[k+1] && div_vld_q[k]) div_q[k+1] <= div_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: pick bypass, zero-gain, saturated or quotient result.
  // --------------------------------------------------------------------------
  ffbc_out_t out_d, out_q;
  div_t      fin;

  always_comb begin
    fin                   = div_q[DIV_STAGES];
    out_d.frame_end       = fin.eof;
    out_d.zero_gain       = 1'b0;
    out_d.saturated       = 1'b0;
    out_d.corrected_pixel = PORT_PIX_W'(fin.p);
    if (fin.use_ff) begin
      if (fin.zg) begin
        out_d.zero_gain       = 1'b1;
        out_d.corrected_pixel = '0;
      end else if (fin.ovf) begin
        out_d.saturated       = 1'b1;
        out_d.corrected_pixel = PORT_PIX_W'({PIX{1'b1}});
      end else begin
        out_d.corrected_pixel = PORT_PIX_W'(fin.quot);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && div_vld_q[DIV_STAGES]) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule
